// ----- hdl/gha_pkg.sv -----
// Shared widths, operation codes and status codes of the generational handle allocator.
package gha_pkg;

  // Default build sizes
  localparam int SLOT_COUNT_DEF = 1024;
  localparam int GEN_BITS_DEF   = 16;

  // Fixed port widths
  localparam int FUNC_W     = 2;
  localparam int IDX_PORT_W = 10;
  localparam int GEN_PORT_W = 16;
  localparam int LIMIT_W    = 11;
  localparam int STAT_W     = 2;
  localparam int CNT_PORT_W = 11;

  // Limit register value after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

endpackage

// ----- hdl/gha_slot_mem.sv -----
// Slot table memory: one write port, one read port with registered read data.
module gha_slot_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 28
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);
  import gha_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/generational_handle_allocator.sv -----
// Top level of the generational handle allocator: control, counters and result register.
//
// Every operation (allocate, free, check) is handled in order: the item is accepted and
// its slot table entry is read; then, once no earlier result is left unaccepted in the
// output register, the read data is evaluated, the entry is written back and the result
// is loaded into the output register. A new item is taken once the previous one has
// reached the output register, so a waiting result does not block the next accept. The
// slot table needs no clearing pass after reset: entries at or above the high-water mark
// count as never used. Handles carry a slot index and a generation; the all-ones generation is never issued.
module generational_handle_allocator #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [gha_pkg::LIMIT_W-1:0]   cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gha_pkg::FUNC_W-1:0]    in_func,
  input  logic [gha_pkg::IDX_PORT_W-1:0] in_handle_index,
  input  logic [gha_pkg::GEN_PORT_W-1:0] in_handle_gen,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gha_pkg::STAT_W-1:0]    out_status,
  output logic [gha_pkg::IDX_PORT_W-1:0] out_result_index,
  output logic [gha_pkg::GEN_PORT_W-1:0] out_result_gen,
  output logic                          out_handle_live,
  output logic [gha_pkg::CNT_PORT_W-1:0] out_live_count
);
  import gha_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W = 2 + GEN_BITS + IDX_W;

  localparam logic [GEN_BITS-1:0] GEN_RESERVED = {GEN_BITS{1'b1}};

  // State codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  logic [LIMIT_W-1:0]    limit_r;
  logic                  head_ok_r, head_ok_nxt;
  logic [IDX_W-1:0]      head_idx_r, head_idx_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic [CNT_W-1:0]      hw_r, hw_nxt;

  // captured item
  logic [FUNC_W-1:0]     func_r;
  logic [IDX_PORT_W-1:0] idx_r;
  logic [GEN_PORT_W-1:0] gen_r;
  logic                  idx_in_range_r;
  logic [IDX_W-1:0]      addr_r;

  // output register
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [IDX_PORT_W-1:0] out_index_r, out_index_nxt;
  logic [GEN_PORT_W-1:0] out_gen_r, out_gen_nxt;
  logic                  out_live_r, out_live_nxt;
  logic [CNT_PORT_W-1:0] out_count_r;

  // memory ports
  logic                  mem_wr_en;
  logic [IDX_W-1:0]      mem_wr_addr;
  logic [ENT_W-1:0]      mem_wr_data;
  logic                  mem_rd_en;
  logic [IDX_W-1:0]      mem_rd_addr;
  logic [ENT_W-1:0]      mem_rd_data;

  // fields of the entry read back
  logic                  rd_live;
  logic [GEN_BITS-1:0]   rd_gen;
  logic                  rd_next_ok;
  logic [IDX_W-1:0]      rd_next;

  logic                  in_fire;
  logic                  finish;
  logic [31:0]           eff_limit;
  logic                  handle_ok;
  logic [GEN_BITS-1:0]   gen_inc;
  logic [GEN_BITS-1:0]   gen_new;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign finish   = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  // Clamp the configured limit to the built depth
  assign eff_limit = (32'(limit_r) > 32'(SLOT_COUNT)) ? 32'(SLOT_COUNT) : 32'(limit_r);

  // Read the head for an allocate, the named slot otherwise
  assign mem_rd_en   = in_fire;
  assign mem_rd_addr = (in_func == FUNC_ALLOC) ? head_idx_r : IDX_W'(in_handle_index);

  assign {rd_live, rd_gen, rd_next_ok, rd_next} = mem_rd_data;

  // Handle names a live slot of the same generation
  assign handle_ok = idx_in_range_r
                  && (32'(idx_r) < 32'(hw_r))
                  && (32'(idx_r) < eff_limit)
                  && rd_live
                  && (32'(rd_gen) == 32'(gen_r));

  // Bump the generation, skipping the reserved value
  assign gen_inc = rd_gen + GEN_BITS'(1);
  assign gen_new = (gen_inc == GEN_RESERVED) ? '0 : gen_inc;

  // Evaluate the operation and form the write-back
  always_comb begin
    state_nxt      = state_r;
    head_ok_nxt    = head_ok_r;
    head_idx_nxt   = head_idx_r;
    live_nxt       = live_r;
    hw_nxt         = hw_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = addr_r;
    mem_wr_data    = '0;
    out_status_nxt = STAT_OK;
    out_index_nxt  = '0;
    out_gen_nxt    = '0;
    out_live_nxt   = 1'b0;

    unique case (func_r)
      FUNC_ALLOC: begin
        if (head_ok_r) begin
          mem_wr_en     = 1'b1;
          mem_wr_data   = {1'b1, gen_new, 1'b0, {IDX_W{1'b0}}};
          head_ok_nxt   = rd_next_ok;
          head_idx_nxt  = rd_next;
          live_nxt      = live_r + CNT_W'(1);
          out_index_nxt = IDX_PORT_W'(addr_r);
          out_gen_nxt   = GEN_PORT_W'(gen_new);
        end else if (32'(hw_r) < eff_limit) begin
          mem_wr_en     = 1'b1;
          mem_wr_addr   = IDX_W'(hw_r);
          mem_wr_data   = {1'b1, {GEN_BITS{1'b0}}, 1'b0, {IDX_W{1'b0}}};
          hw_nxt        = hw_r + CNT_W'(1);
          live_nxt      = live_r + CNT_W'(1);
          out_index_nxt = IDX_PORT_W'(hw_r);
        end else begin
          out_status_nxt = STAT_FULL;
        end
      end
      FUNC_FREE: begin
        if (handle_ok) begin
          mem_wr_en    = 1'b1;
          mem_wr_data  = {1'b0, rd_gen, head_ok_r, head_idx_r};
          head_ok_nxt  = 1'b1;
          head_idx_nxt = addr_r;
          if (live_r != '0) begin
            live_nxt = live_r - CNT_W'(1);
          end
        end else begin
          out_status_nxt = STAT_INVALID;
        end
      end
      FUNC_CHECK: begin
        out_live_nxt = handle_ok;
      end
      default: begin
        // unused code: no operation
      end
    endcase

    // Hold everything unless the item completes this cycle
    if (!finish) begin
      head_ok_nxt  = head_ok_r;
      head_idx_nxt = head_idx_r;
      live_nxt     = live_r;
      hw_nxt       = hw_r;
      mem_wr_en    = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (finish)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      head_ok_r   <= 1'b0;
      head_idx_r  <= '0;
      live_r      <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_ok_r  <= head_ok_nxt;
      head_idx_r <= head_idx_nxt;
      live_r     <= live_nxt;
      hw_r       <= hw_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r         <= in_func;
      idx_r          <= in_handle_index;
      gen_r          <= in_handle_gen;
      idx_in_range_r <= (32'(in_handle_index) < 32'(SLOT_COUNT));
      addr_r         <= mem_rd_addr;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_gen_r    <= out_gen_nxt;
      out_live_r   <= out_live_nxt;
      out_count_r  <= CNT_PORT_W'(live_nxt);
    end
  end

  gha_slot_mem #(
    .DEPTH  (SLOT_COUNT),
    .DATA_W (ENT_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_index_r;
  assign out_result_gen   = out_gen_r;
  assign out_handle_live  = out_live_r;
  assign out_live_count   = out_count_r;

endmodule

// ----- hdl/gha_checker.sv -----
// Port-level assertions for the generational handle allocator, bound to the top level.
module gha_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gha_pkg::STAT_W-1:0]     out_status,
  input logic [gha_pkg::IDX_PORT_W-1:0] out_result_index,
  input logic [gha_pkg::GEN_PORT_W-1:0] out_result_gen,
  input logic                           out_handle_live,
  input logic [gha_pkg::CNT_PORT_W-1:0] out_live_count
);
  import gha_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_result_index) && $stable(out_result_gen)
      && $stable(out_handle_live) && $stable(out_live_count))
    else $error("stalled result changed");

  // Drop ready for the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one still executing");

  // A full table returns no handle
  a_full_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |->
      (out_result_index == '0) && (out_result_gen == '0) && !out_handle_live)
    else $error("full status with handle fields set");

  // A live check comes with ok status and a zero result generation
  a_live_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_handle_live |-> (out_status == STAT_OK) && (out_result_gen == '0))
    else $error("handle_live with wrong status or generation");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_result_index (out_result_index),
  .out_result_gen   (out_result_gen),
  .out_handle_live  (out_handle_live),
  .out_live_count   (out_live_count)
);

// ----- bench/generational_handle_allocator_test.sv -----
// Self-checking testbench of the generational handle allocator: directed, stall and random tests.
module generational_handle_allocator_test;
  import gha_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int PRINT_LIMIT = 100;

  // One expected result item
  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [IDX_PORT_W-1:0] slot;
    logic [GEN_PORT_W-1:0] gen;
    logic                  live;
    logic [CNT_PORT_W-1:0] count;
  } reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [LIMIT_W-1:0]    cfg_wr_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func;
  logic [IDX_PORT_W-1:0] in_handle_index;
  logic [GEN_PORT_W-1:0] in_handle_gen;
  logic                  out_valid;
  logic                  out_ready;
  logic [STAT_W-1:0]     out_status;
  logic [IDX_PORT_W-1:0] out_result_index;
  logic [GEN_PORT_W-1:0] out_result_gen;
  logic                  out_handle_live;
  logic [CNT_PORT_W-1:0] out_live_count;

  // Slot table shadow, free list and counters
  logic                  tbl_live    [SLOTS];
  logic [GEN_PORT_W-1:0] tbl_gen     [SLOTS];
  logic                  tbl_link_ok [SLOTS];
  logic [IDX_PORT_W-1:0] tbl_link    [SLOTS];
  logic                  fl_head_ok;
  logic [IDX_PORT_W-1:0] fl_head;
  int                    live_now;
  int                    hwm;
  int                    cap_limit;

  reply_t expected_replies[$];
  int     mismatch_count = 0;
  int     results_seen = 0;
  int     cycle_count = 0;
  bit     tx_idle_on = 1'b1;
  bit     rx_idle_on = 1'b1;
  int     rx_hold_cycles = 0;

  generational_handle_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_handle_index  (in_handle_index),
    .in_handle_gen    (in_handle_gen),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_result_index (out_result_index),
    .out_result_gen   (out_result_gen),
    .out_handle_live  (out_handle_live),
    .out_live_count   (out_live_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int eff_limit();
    return (cap_limit > SLOTS) ? SLOTS : cap_limit;
  endfunction

  function automatic bit handle_matches(logic [IDX_PORT_W-1:0] idx, logic [GEN_PORT_W-1:0] g);
    if (int'(idx) >= eff_limit())
      return 1'b0;
    return tbl_live[idx] && (tbl_gen[idx] == g);
  endfunction

  task automatic clear_slot_model();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_live[i]    = 1'b0;
      tbl_gen[i]     = '0;
      tbl_link_ok[i] = 1'b0;
      tbl_link[i]    = '0;
    end
    fl_head_ok = 1'b0;
    fl_head    = '0;
    live_now   = 0;
    hwm        = 0;
    cap_limit  = int'(LIMIT_RESET);
  endtask

  // Apply one accepted item to the shadow state and queue its result
  task automatic apply_slot_op(logic [FUNC_W-1:0] f, logic [IDX_PORT_W-1:0] idx,
                               logic [GEN_PORT_W-1:0] g);
    reply_t                r;
    logic [IDX_PORT_W-1:0] s;
    logic [GEN_PORT_W-1:0] ng;
    r = '0;
    case (f)
      FUNC_ALLOC: begin
        if (fl_head_ok) begin
          // pop the most recently freed slot and bump its generation
          s  = fl_head;
          ng = tbl_gen[s] + 1'b1;
          if (ng == '1)
            ng = '0;
          fl_head_ok     = tbl_link_ok[s];
          fl_head        = tbl_link[s];
          tbl_live[s]    = 1'b1;
          tbl_gen[s]     = ng;
          tbl_link_ok[s] = 1'b0;
          tbl_link[s]    = '0;
          live_now++;
          r.slot = s;
          r.gen  = ng;
        end else if (hwm < eff_limit()) begin
          // take the never-used slot at the high-water mark
          s = hwm[IDX_PORT_W-1:0];
          tbl_live[s]    = 1'b1;
          tbl_gen[s]     = '0;
          tbl_link_ok[s] = 1'b0;
          tbl_link[s]    = '0;
          hwm++;
          live_now++;
          r.slot = s;
        end else begin
          r.status = STAT_FULL;
        end
      end
      FUNC_FREE: begin
        if (int'(idx) < hwm && handle_matches(idx, g)) begin
          // push the slot onto the free list
          tbl_live[idx]    = 1'b0;
          tbl_link_ok[idx] = fl_head_ok;
          tbl_link[idx]    = fl_head;
          fl_head_ok       = 1'b1;
          fl_head          = idx;
          if (live_now > 0)
            live_now--;
        end else begin
          r.status = STAT_INVALID;
        end
      end
      FUNC_CHECK: r.live = handle_matches(idx, g);
      default: ;
    endcase
    r.count = live_now[CNT_PORT_W-1:0];
    expected_replies.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch on %s of result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
  endtask

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_result_index !== want.slot)
          report_mismatch("result_index", int'(out_result_index), int'(want.slot));
        if (out_result_gen !== want.gen)
          report_mismatch("result_gen", int'(out_result_gen), int'(want.gen));
        if (out_handle_live !== want.live)
          report_mismatch("handle_live", int'(out_handle_live), int'(want.live));
        if (out_live_count !== want.count)
          report_mismatch("live_count", int'(out_live_count), int'(want.count));
      end
      results_seen++;
    end
  end

  // Drive out_ready: a requested long hold-off takes priority, otherwise random bursts of idling
  initial begin
    int gap;
    gap = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item, hold it until accepted, then predict its result
  task automatic send_op(logic [FUNC_W-1:0] f, logic [IDX_PORT_W-1:0] idx,
                         logic [GEN_PORT_W-1:0] g);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_handle_index <= idx;
    in_handle_gen   <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_slot_op(f, idx, g);
  endtask

  // Drop valid and wait until every result item has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(int value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[LIMIT_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_limit = value;
  endtask

  // Mostly allocates and well-formed frees and checks of known handles, some noise
  task automatic random_op();
    int                    r;
    int                    bound;
    int                    alloc_share;
    int                    top;
    logic [FUNC_W-1:0]     f;
    logic [IDX_PORT_W-1:0] idx;
    logic [GEN_PORT_W-1:0] g;
    bound = (hwm < eff_limit()) ? hwm : eff_limit();
    top   = (hwm < SLOTS) ? hwm : SLOTS - 1;
    if ($urandom_range(0, 99) < 10) begin
      f   = FUNC_W'($urandom_range(0, 3));
      idx = IDX_PORT_W'($urandom_range(0, SLOTS - 1));
      g   = GEN_PORT_W'($urandom_range(0, 65535));
    end else begin
      alloc_share = (live_now >= eff_limit() && !fl_head_ok) ? 15 : 40;
      r = $urandom_range(0, 99);
      if (r < alloc_share)
        f = FUNC_ALLOC;
      else if (r < alloc_share + 35)
        f = FUNC_FREE;
      else
        f = FUNC_CHECK;
      if (bound > 0 && $urandom_range(0, 4) != 0)
        idx = IDX_PORT_W'($urandom_range(0, bound - 1));
      else
        idx = IDX_PORT_W'($urandom_range(0, top));
      g = tbl_gen[idx];
      if ($urandom_range(0, 7) == 0)
        g = g + GEN_PORT_W'($urandom_range(1, 2));
      if (f == FUNC_ALLOC) begin
        idx = IDX_PORT_W'($urandom_range(0, SLOTS - 1));
        g   = GEN_PORT_W'($urandom_range(0, 65535));
      end
    end
    send_op(f, idx, g);
  endtask

  // Never-used slots, an invalid free and the unused operation code
  task automatic test_fresh_table();
    send_op(FUNC_CHECK, 10'd0, 16'd0);
    send_op(FUNC_FREE, 10'd0, 16'd0);
    send_op(FUNC_NOP, 10'd1023, 16'hFFFF);
  endtask

  // Allocate, check, free, stale handles and LIFO reuse
  task automatic test_basic_ops();
    send_op(FUNC_ALLOC, 10'd0, 16'd0);
    send_op(FUNC_ALLOC, 10'd1023, 16'hFFFF);
    send_op(FUNC_ALLOC, 10'd0, 16'd0);
    send_op(FUNC_CHECK, 10'd1, 16'd0);
    send_op(FUNC_CHECK, 10'd1, 16'd1);
    send_op(FUNC_CHECK, 10'd1023, 16'hFFFF);
    send_op(FUNC_FREE, 10'd1, 16'd5);
    send_op(FUNC_FREE, 10'd1, 16'd0);
    send_op(FUNC_CHECK, 10'd1, 16'd0);
    send_op(FUNC_FREE, 10'd1, 16'd0);
    send_op(FUNC_FREE, 10'd2, 16'd0);
    send_op(FUNC_ALLOC, 10'd0, 16'd0);
    send_op(FUNC_ALLOC, 10'd0, 16'd0);
    send_op(FUNC_ALLOC, 10'd0, 16'd0);
    send_op(FUNC_CHECK, 10'd2, 16'd0);
    send_op(FUNC_CHECK, 10'd2, 16'd1);
    send_op(FUNC_FREE, 10'd1023, 16'hFFFF);
    send_op(FUNC_NOP, 10'd0, 16'd0);
  endtask

  // Fill every slot, then allocate into a full table
  task automatic test_fill_table();
    write_capacity(SLOTS);
    while (fl_head_ok || hwm < eff_limit())
      send_op(FUNC_ALLOC, IDX_PORT_W'($urandom_range(0, SLOTS - 1)),
              GEN_PORT_W'($urandom_range(0, 65535)));
    send_op(FUNC_ALLOC, 10'd0, 16'd0);
    send_op(FUNC_ALLOC, 10'd1023, 16'hFFFF);
    send_op(FUNC_CHECK, 10'd1023, tbl_gen[1023]);
  endtask

  // Lower the limit with slots on the free list, then raise it past the depth
  task automatic test_lowered_limit();
    send_op(FUNC_FREE, 10'd1023, tbl_gen[1023]);
    send_op(FUNC_FREE, 10'd700, tbl_gen[700]);
    send_op(FUNC_FREE, 10'd3, tbl_gen[3]);
    send_op(FUNC_FREE, 10'd0, tbl_gen[0]);
    send_op(FUNC_FREE, 10'd512, tbl_gen[512]);
    write_capacity(1);
    send_op(FUNC_CHECK, 10'd5, tbl_gen[5]);
    send_op(FUNC_FREE, 10'd5, tbl_gen[5]);
    send_op(FUNC_CHECK, 10'd0, tbl_gen[0]);
    repeat (6) send_op(FUNC_ALLOC, 10'd0, 16'd0);
    send_op(FUNC_FREE, 10'd0, tbl_gen[0]);
    send_op(FUNC_ALLOC, 10'd0, 16'd0);
    send_op(FUNC_CHECK, 10'd0, tbl_gen[0]);
    write_capacity(2047);
    send_op(FUNC_CHECK, 10'd1023, tbl_gen[1023]);
    send_op(FUNC_ALLOC, 10'd0, 16'd0);
    write_capacity(SLOTS);
  endtask

  // Free and reallocate one slot back to back so its generation keeps advancing
  task automatic test_slot_reuse();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (10) begin
      send_op(FUNC_FREE, 10'd0, tbl_gen[0]);
      send_op(FUNC_ALLOC, 10'd0, 16'd0);
    end
    send_op(FUNC_CHECK, 10'd0, tbl_gen[0]);
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold off the result side long enough that the input stalls
  task automatic test_stalled_output();
    tx_idle_on = 1'b0;
    rx_hold_cycles = 300;
    repeat (40) random_op();
    drain_results();
    tx_idle_on = 1'b1;
  endtask

  // Random items over several limits; the last phase runs without idling
  task automatic test_random_mix();
    int phase_limits [8] = '{1024, 1, 3, 37, 2047, 512, 1536, 16};
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_limits[p]);
      if (p == 7) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      repeat (65) random_op();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_NOP;
    in_handle_index <= '0;
    in_handle_gen   <= '0;
    clear_slot_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fresh_table();
    test_basic_ops();
    test_fill_table();
    test_lowered_limit();
    test_slot_reuse();
    test_stalled_output();
    test_random_mix();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
